// ===== sv/usb_control_request_responder_assert.svh =====
// assertion macros used by the responder datapath
`ifndef USB_CONTROL_REQUEST_RESPONDER_ASSERT_SVH
`define USB_CONTROL_REQUEST_RESPONDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define USBCRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("usbcrr check failed");
// next-cycle implication
`define USBCRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("usbcrr check failed");
`else
`define USBCRR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define USBCRR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/usbcrr_pkg.sv =====
`default_nettype none
package usbcrr_pkg;

  // ep0 max packet size reported in the device descriptor
  localparam int MAX_PACKET = 64;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_VENDOR_ID  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_ID = 1'd1;

  // {bRequest, bmRequestType}
  localparam logic [15:0] REQ_GET_DESCRIPTOR = 16'h0680;
  localparam logic [15:0] REQ_SET_ADDRESS    = 16'h0500;
  localparam logic [15:0] REQ_SET_CONFIG     = 16'h0900;
  localparam logic [15:0] REQ_GET_CONFIG     = 16'h0880;
  localparam logic [15:0] REQ_GET_STATUS     = 16'h0080;
  localparam logic [15:0] REQ_GET_INTERFACE  = 16'h0a81;
  localparam logic [15:0] REQ_SET_INTERFACE  = 16'h0b01;

  localparam logic [15:0] DESC_DEVICE = 16'h0100;
  localparam logic [15:0] DESC_CONFIG = 16'h0200;
  localparam logic [15:0] ADDR_LIMIT  = 16'd128;

  localparam logic [5:0] DEV_LEN = 6'd18;
  localparam logic [5:0] CFG_LEN = 6'd32;

  typedef enum logic [2:0] {
    ACT_DATA  = 3'd0,
    ACT_EMPTY = 3'd1,
    ACT_ACK   = 3'd2,
    ACT_STALL = 3'd3,
    ACT_RESET = 3'd4
  } action_t;

  localparam logic [7:0] CFG_DESC [32] = '{
    8'd9, 8'd2, 8'd32, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'hff, 8'd0, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h01, 8'd2, 8'd64, 8'd0, 8'd0,
    8'd7, 8'd5, 8'h82, 8'd2, 8'd64, 8'd0, 8'd0
  };

  function automatic logic [7:0] dev_desc_byte(input logic [4:0] idx,
                                               input logic [15:0] vid,
                                               input logic [15:0] pid);
    logic [7:0] b;
    b = 8'd0;
    case (idx)
      5'd0:    b = 8'd18;
      5'd1:    b = 8'd1;
      5'd3:    b = 8'd2;
      5'd7:    b = 8'(MAX_PACKET);
      5'd8:    b = vid[7:0];
      5'd9:    b = vid[15:8];
      5'd10:   b = pid[7:0];
      5'd11:   b = pid[15:8];
      5'd13:   b = 8'd1;
      5'd17:   b = 8'd1;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic load;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_result;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/usb_control_request_responder.sv =====
`default_nettype none
// control endpoint responder for usb standard requests. each input item is a
// setup packet (in_func 0) or a bus reset / detach event (in_func 1). a setup
// item is answered with a run of result items: descriptor or status bytes one
// per item (action 0, cut to wLength), or a single empty packet, status ack or
// stall; a bus reset answers with one reset-done item. out_last marks the
// final result of each input item, out_configured_now carries the configured
// flag as it stands after the item and out_pipes_reset flags set
// configuration and bus reset. the item is captured, then its results follow
// as the output register frees up, paced by the single byte counter stepping
// through the reply. the next item is taken once the last result has moved
// into the output register, which lets the consumer stall without holding
// up capture. vendor and product ids are written through the cfg port (index
// 0 vendor, 1 product); the user must do so only while idle, not enforced here.
module usb_control_request_responder (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // config writes
  input  wire logic                             cfg_wr_en,
  input  wire logic [usbcrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                      cfg_wdata,
  // setup / bus event items
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_func,
  input  wire logic [7:0]                       in_request_type,
  input  wire logic [7:0]                       in_request_code,
  input  wire logic [15:0]                      in_setup_value,
  input  wire logic [15:0]                      in_setup_index,
  input  wire logic [15:0]                      in_setup_length,
  // result items
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [2:0]                            out_action,
  output logic [7:0]                            out_data_byte,
  output logic                                  out_last,
  output logic                                  out_configured_now,
  output logic                                  out_pipes_reset
);

  // command and status between sequencer and datapath
  usbcrr_pkg::ctrl_cmd_t  cmd;
  usbcrr_pkg::dp_status_t status;

  // sequencer: idle waits for an item, send walks the results
  usbcrr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: request decode, byte counter, descriptor rom, output register
  usbcrr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_func            (in_func),
    .in_request_type    (in_request_type),
    .in_request_code    (in_request_code),
    .in_setup_value     (in_setup_value),
    .in_setup_index     (in_setup_index),
    .in_setup_length    (in_setup_length),
    .cmd                (cmd),
    .status             (status),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_action         (out_action),
    .out_data_byte      (out_data_byte),
    .out_last           (out_last),
    .out_configured_now (out_configured_now),
    .out_pipes_reset    (out_pipes_reset)
  );

endmodule
`default_nettype wire

// ===== sv/usbcrr_ctrl.sv =====
`default_nettype none
module usbcrr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire usbcrr_pkg::dp_status_t status,
  output usbcrr_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  state_t state_r;

  assign in_ready = (state_r == ST_IDLE);
  assign cmd.load = in_valid && (state_r == ST_IDLE);
  assign cmd.emit = (state_r == ST_SEND) && status.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) state_r <= ST_SEND;
        end
        ST_SEND: begin
          if (cmd.emit && status.last_result) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/usbcrr_dp.sv =====
`default_nettype none
`include "usb_control_request_responder_assert.svh"
module usbcrr_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [usbcrr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [15:0]                         cfg_wdata,
  input  wire logic                                in_func,
  input  wire logic [7:0]                          in_request_type,
  input  wire logic [7:0]                          in_request_code,
  input  wire logic [15:0]                         in_setup_value,
  input  wire logic [15:0]                         in_setup_index,
  input  wire logic [15:0]                         in_setup_length,
  input  wire usbcrr_pkg::ctrl_cmd_t               cmd,
  output usbcrr_pkg::dp_status_t                   status,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [2:0]                               out_action,
  output logic [7:0]                               out_data_byte,
  output logic                                     out_last,
  output logic                                     out_configured_now,
  output logic                                     out_pipes_reset
);

  logic [15:0] vendor_id_r, product_id_r;
  logic        configured_r, configured_nxt;
  logic [5:0]  byte_cnt_r, byte_cnt_nxt;

  // captured setup item
  logic        func_r;
  logic [15:0] req_r, value_r, index_r, length_r;

  // output register
  logic                 out_valid_r;
  usbcrr_pkg::action_t  action_r;
  logic [7:0]           data_byte_r;
  logic                 last_r, configured_now_r, pipes_reset_r;

  // decode
  logic get_dev, get_cfg, set_addr, set_cfg, get_conf, get_stat, get_if, set_if;
  logic is_data, plain_ok;
  logic [5:0] desc_size, desc_n, reply_n;
  logic last_result;
  usbcrr_pkg::action_t act;
  logic [7:0] reply_byte;

  always_comb begin
    plain_ok = (value_r == 16'd0) && (index_r == 16'd0);
    get_dev  = !func_r && (req_r == usbcrr_pkg::REQ_GET_DESCRIPTOR)
               && (index_r == 16'd0) && (value_r == usbcrr_pkg::DESC_DEVICE);
    get_cfg  = !func_r && (req_r == usbcrr_pkg::REQ_GET_DESCRIPTOR)
               && (index_r == 16'd0) && (value_r == usbcrr_pkg::DESC_CONFIG);
    set_addr = !func_r && (req_r == usbcrr_pkg::REQ_SET_ADDRESS)
               && (value_r < usbcrr_pkg::ADDR_LIMIT) && (index_r == 16'd0)
               && (length_r == 16'd0);
    set_cfg  = !func_r && (req_r == usbcrr_pkg::REQ_SET_CONFIG)
               && (value_r <= 16'd1) && (index_r == 16'd0) && (length_r == 16'd0);
    get_conf = !func_r && (req_r == usbcrr_pkg::REQ_GET_CONFIG) && plain_ok
               && (length_r == 16'd1);
    get_stat = !func_r && (req_r == usbcrr_pkg::REQ_GET_STATUS) && plain_ok
               && (length_r == 16'd2);
    get_if   = !func_r && (req_r == usbcrr_pkg::REQ_GET_INTERFACE) && plain_ok
               && (length_r == 16'd1) && configured_r;
    set_if   = !func_r && (req_r == usbcrr_pkg::REQ_SET_INTERFACE) && plain_ok
               && (length_r == 16'd0) && configured_r;
    is_data  = get_dev || get_cfg || get_conf || get_stat || get_if;

    // descriptor replies are cut to wLength
    desc_size = get_cfg ? usbcrr_pkg::CFG_LEN : usbcrr_pkg::DEV_LEN;
    desc_n    = (length_r < {10'd0, desc_size}) ? length_r[5:0] : desc_size;
    priority if (get_dev || get_cfg) begin
      reply_n = desc_n;
    end else if (get_stat) begin
      reply_n = 6'd2;
    end else begin
      reply_n = 6'd1;
    end

    priority if (func_r) begin
      act = usbcrr_pkg::ACT_RESET;
    end else if (is_data) begin
      act = (reply_n == 6'd0) ? usbcrr_pkg::ACT_EMPTY : usbcrr_pkg::ACT_DATA;
    end else if (set_addr || set_cfg || set_if) begin
      act = usbcrr_pkg::ACT_ACK;
    end else begin
      act = usbcrr_pkg::ACT_STALL;
    end

    last_result = (act != usbcrr_pkg::ACT_DATA) || (byte_cnt_r + 6'd1 == reply_n);

    priority if (act != usbcrr_pkg::ACT_DATA) begin
      reply_byte = 8'd0;
    end else if (get_dev) begin
      reply_byte = usbcrr_pkg::dev_desc_byte(byte_cnt_r[4:0], vendor_id_r, product_id_r);
    end else if (get_cfg) begin
      reply_byte = usbcrr_pkg::CFG_DESC[byte_cnt_r[4:0]];
    end else if (get_conf) begin
      reply_byte = {7'd0, configured_r};
    end else begin
      reply_byte = 8'd0;
    end

    priority if (func_r) begin
      configured_nxt = 1'b0;
    end else if (set_cfg) begin
      configured_nxt = value_r[0];
    end else begin
      configured_nxt = configured_r;
    end

    byte_cnt_nxt = last_result ? 6'd0 : byte_cnt_r + 6'd1;
  end

  assign status.out_free    = !out_valid_r || out_ready;
  assign status.last_result = last_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vendor_id_r  <= 16'hffff;
      product_id_r <= 16'hffff;
      configured_r <= 1'b0;
      byte_cnt_r   <= 6'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          usbcrr_pkg::REG_VENDOR_ID:  vendor_id_r  <= cfg_wdata;
          usbcrr_pkg::REG_PRODUCT_ID: product_id_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        byte_cnt_r <= 6'd0;
      end else if (cmd.emit) begin
        byte_cnt_r <= byte_cnt_nxt;
        if (last_result) configured_r <= configured_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      req_r    <= {in_request_code, in_request_type};
      value_r  <= in_setup_value;
      index_r  <= in_setup_index;
      length_r <= in_setup_length;
    end
    if (cmd.emit) begin
      action_r         <= act;
      data_byte_r      <= reply_byte;
      last_r           <= last_result;
      configured_now_r <= configured_nxt;
      pipes_reset_r    <= func_r || set_cfg;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = action_r;
  assign out_data_byte      = data_byte_r;
  assign out_last           = last_r;
  assign out_configured_now = configured_now_r;
  assign out_pipes_reset    = pipes_reset_r;

  `USBCRR_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !out_valid_r || out_ready)
  `USBCRR_ASSERT_NXT(a_cnt_clear, clk, rst_n, cmd.emit && last_result, byte_cnt_r == 6'd0)
  `USBCRR_ASSERT_NXT(a_cfg_hold, clk, rst_n, !(cmd.emit && last_result),
                     configured_r == $past(configured_r))

endmodule
`default_nettype wire
